// ===== hw/rtl/functional_graph_closest_meeting_node_defines.svh =====
// ----------------------------------------------------------------------------
// functional_graph_closest_meeting_node_defines
// assertion macros shared by the checker files of the meeting node block
// ----------------------------------------------------------------------------
`ifndef FUNCTIONAL_GRAPH_CLOSEST_MEETING_NODE_DEFINES_SVH
`define FUNCTIONAL_GRAPH_CLOSEST_MEETING_NODE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FGCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fgcm check failed");

// next-cycle implication, checked outside reset
`define FGCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fgcm check failed");

`endif

// ===== hw/rtl/fgcm_pkg.sv =====
// ----------------------------------------------------------------------------
// fgcm_pkg
// shared constants, types and controller commands of the meeting node block
// ----------------------------------------------------------------------------
package fgcm_pkg;

  // graph size
  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int COUNT_W   = NODE_W + 1;
  localparam int EDGE_W    = NODE_W + 1;

  // visit tags: epoch zero means never visited
  localparam int EPOCH_W    = 8;
  localparam int EPOCH_LAST = (1 << EPOCH_W) - 1;
  localparam int DIST_A_W   = EPOCH_W + NODE_W;

  // request opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_ISSUE,
    ST_A_STEP,
    ST_B_ISSUE,
    ST_B_STEP,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr;        // clear one tag entry
    logic take;       // accept a request
    logic init_b;     // restart the walker at the second start
    logic walk_b;     // walker follows the second start
    logic step;       // one hop of the walker
    logic epoch_adv;  // query finished
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic cur_ok;
    logic visited;
    logic cont;
    logic epoch_last;
  } status_t;

endpackage

// ===== hw/rtl/fgcm_ram.sv =====
// ----------------------------------------------------------------------------
// fgcm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module fgcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read, old data on a colliding address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fgcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fgcm_ctrl
// sequencer: tag clearing, request accept, two chain walks, result strobe
// ----------------------------------------------------------------------------
module fgcm_ctrl import fgcm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    opcode,
  input  status_t sts,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.take = 1'b1;
          if (opcode == OP_QUERY) begin
            state_next = ST_A_ISSUE;
          end
        end
      end
      ST_A_ISSUE: begin
        if (sts.cur_ok) begin
          state_next = ST_A_STEP;
        end else begin
          cmd.init_b = 1'b1;
          state_next = ST_B_ISSUE;
        end
      end
      ST_A_STEP: begin
        cmd.step = 1'b1;
        if (sts.visited || !sts.cont) begin
          cmd.init_b = 1'b1;
          state_next = ST_B_ISSUE;
        end
      end
      ST_B_ISSUE: begin
        cmd.walk_b = 1'b1;
        if (sts.cur_ok) begin
          state_next = ST_B_STEP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_B_STEP: begin
        cmd.walk_b = 1'b1;
        cmd.step   = 1'b1;
        if (sts.visited || !sts.cont) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        done          = 1'b1;
        cmd.epoch_adv = 1'b1;
        state_next    = sts.epoch_last ? ST_CLEAR : ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== hw/rtl/fgcm_dp.sv =====
// ----------------------------------------------------------------------------
// fgcm_dp
// datapath: edge memory, visit tag memories, chain walker and best tracker
// ----------------------------------------------------------------------------
module fgcm_dp import fgcm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            sts,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               opcode,
  input  logic [NODE_W-1:0]  node_index,
  input  logic               has_edge,
  input  logic [NODE_W-1:0]  edge_target,
  input  logic [NODE_W-1:0]  start_a,
  input  logic [NODE_W-1:0]  start_b,
  output logic               found,
  output logic [NODE_W-1:0]  meeting_node
);

  logic [COUNT_W-1:0]  nc;
  logic [EPOCH_W-1:0]  epoch;
  logic [NODE_W-1:0]   clr_addr;
  logic [NODE_W-1:0]   cur;
  logic [NODE_W-1:0]   prev_cur;
  logic [NODE_W-1:0]   qb;
  logic [NODE_W-1:0]   hops;
  logic [NODE_W-1:0]   best;
  logic [NODE_W-1:0]   best_max;
  logic                chain;
  logic                found_r;

  logic [EDGE_W-1:0]   edge_rd;
  logic [DIST_A_W-1:0] da_rd;
  logic [EPOCH_W-1:0]  db_rd;

  logic [NODE_W-1:0]   tgt;
  logic                cont;
  logic [EPOCH_W-1:0]  own_tag;
  logic                visited;
  logic                a_hit;
  logic [NODE_W-1:0]   da;
  logic [NODE_W-1:0]   m;
  logic                better;
  logic                wr;
  logic [NODE_W-1:0]   rd_addr;
  logic                edge_we;
  logic [EDGE_W-1:0]   edge_wdata;
  logic                da_we;
  logic                db_we;
  logic [NODE_W-1:0]   dist_waddr;
  logic [DIST_A_W-1:0] da_wdata;
  logic [EPOCH_W-1:0]  db_wdata;
  logic [COUNT_W-1:0]  nc_clamped;

  // walker decode of the node just read
  always_comb begin
    tgt     = edge_rd[NODE_W-1:0];
    cont    = !edge_rd[NODE_W] && ({1'b0, tgt} < nc);
    own_tag = cmd.walk_b ? db_rd : da_rd[DIST_A_W-1 -: EPOCH_W];
    // a self loop is written in the same cycle it is read back
    visited = (own_tag == epoch) || (chain && (cur == prev_cur));
    wr      = cmd.step && !visited;
    rd_addr = (wr && cont) ? tgt : cur;
  end

  // candidate meeting node on the second walk
  always_comb begin
    a_hit  = (da_rd[DIST_A_W-1 -: EPOCH_W] == epoch);
    da     = da_rd[NODE_W-1:0];
    m      = (da > hops) ? da : hops;
    better = a_hit && (!found_r || (m < best_max) || ((m == best_max) && (cur < best)));
  end

  // memory write ports
  always_comb begin
    edge_we    = cmd.take && (opcode == OP_LOAD) && ({1'b0, node_index} < nc);
    edge_wdata = has_edge ? {1'b0, edge_target} : {1'b1, {NODE_W{1'b0}}};
    da_we      = cmd.clr || (wr && !cmd.walk_b);
    db_we      = cmd.clr || (wr && cmd.walk_b);
    dist_waddr = cmd.clr ? clr_addr : cur;
    da_wdata   = cmd.clr ? '0 : {epoch, hops};
    db_wdata   = cmd.clr ? '0 : epoch;
  end

  // node count saturates into 1..MAX_NODES
  always_comb begin
    if (cfg_wdata == '0) begin
      nc_clamped = COUNT_W'(1);
    end else if (cfg_wdata > COUNT_W'(MAX_NODES)) begin
      nc_clamped = COUNT_W'(MAX_NODES);
    end else begin
      nc_clamped = cfg_wdata;
    end
  end

  // status to the controller
  always_comb begin
    sts.clr_last   = (clr_addr == NODE_W'(MAX_NODES - 1));
    sts.cur_ok     = ({1'b0, cur} < nc);
    sts.visited    = visited;
    sts.cont       = cont;
    sts.epoch_last = (epoch == EPOCH_W'(EPOCH_LAST));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nc       <= COUNT_W'(MAX_NODES);
      epoch    <= EPOCH_W'(1);
      clr_addr <= '0;
      chain    <= 1'b0;
    end else begin
      if (cfg_we) begin
        nc <= nc_clamped;
      end
      if (cmd.clr) begin
        clr_addr <= clr_addr + NODE_W'(1);
      end
      if (cmd.epoch_adv) begin
        epoch <= sts.epoch_last ? EPOCH_W'(1) : epoch + EPOCH_W'(1);
      end
      if (cmd.take || cmd.init_b) begin
        chain <= 1'b0;
      end else if (wr) begin
        chain <= 1'b1;
      end
    end
  end

  // walker and best tracker
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur      <= start_a;
      qb       <= start_b;
      hops     <= '0;
      found_r  <= 1'b0;
      best     <= '0;
      best_max <= '0;
    end
    if (wr) begin
      hops     <= hops + NODE_W'(1);
      prev_cur <= cur;
      if (cont) begin
        cur <= tgt;
      end
      if (cmd.walk_b && better) begin
        found_r  <= 1'b1;
        best     <= cur;
        best_max <= m;
      end
    end
    if (cmd.init_b) begin
      cur  <= qb;
      hops <= '0;
    end
  end

  assign found        = found_r;
  assign meeting_node = best;

  // edge store
  fgcm_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_NODES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (node_index),
    .wdata (edge_wdata),
    .raddr (rd_addr),
    .rdata (edge_rd)
  );

  // visit tag and hop distance from the first start
  fgcm_ram #(.WIDTH(DIST_A_W), .DEPTH(MAX_NODES)) u_dist_a_ram (
    .clk   (clk),
    .we    (da_we),
    .waddr (dist_waddr),
    .wdata (da_wdata),
    .raddr (rd_addr),
    .rdata (da_rd)
  );

  // visit tag from the second start
  fgcm_ram #(.WIDTH(EPOCH_W), .DEPTH(MAX_NODES)) u_dist_b_ram (
    .clk   (clk),
    .we    (db_we),
    .waddr (dist_waddr),
    .wdata (db_wdata),
    .raddr (rd_addr),
    .rdata (db_rd)
  );

endmodule

// ===== hw/rtl/functional_graph_closest_meeting_node.sv =====
// ----------------------------------------------------------------------------
// functional_graph_closest_meeting_node
// closest common reachable node of two starts in a one-edge-per-node graph
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A load request writes
// one node's edge as it is taken and gives no result. After a query is taken,
// busy stays high while the walker follows the chain from each start in turn,
// at most node_count nodes each, reading one node per cycle from the edge
// memory. The result shows on found and meeting_node for exactly the one cycle
// that done is high, the last busy cycle of the query; the receiver cannot
// stall it. After reset, and after every 255th query, the block clears all
// 1024 visit tag entries with busy high; configuration writes are still taken
// then.
module functional_graph_closest_meeting_node import fgcm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic [NODE_W-1:0]  node_index,
  input  logic               has_edge,
  input  logic [NODE_W-1:0]  edge_target,
  input  logic [NODE_W-1:0]  start_a,
  input  logic [NODE_W-1:0]  start_b,
  output logic               done,
  output logic               found,
  output logic [NODE_W-1:0]  meeting_node
);

  cmd_t    cmd;
  status_t sts;

  // sequencer
  fgcm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // memories and walker
  fgcm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .opcode       (opcode),
    .node_index   (node_index),
    .has_edge     (has_edge),
    .edge_target  (edge_target),
    .start_a      (start_a),
    .start_b      (start_b),
    .found        (found),
    .meeting_node (meeting_node)
  );

endmodule

// ===== hw/rtl/fgcm_checker.sv =====
// ----------------------------------------------------------------------------
// fgcm_checker
// port level checks of the meeting node block, bound to the top level
// ----------------------------------------------------------------------------
`include "functional_graph_closest_meeting_node_defines.svh"

module fgcm_checker import fgcm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               opcode,
  input logic               done,
  input logic               found,
  input logic [NODE_W-1:0]  meeting_node
);

  // a result only comes while a query is in flight
  `FGCM_ASSERT_NOW(a_done_busy, done, busy)

  // the result strobe lasts one cycle
  `FGCM_ASSERT_NEXT(a_done_pulse, done, !done)

  // no meeting node means a zero node number
  `FGCM_ASSERT_NOW(a_miss_zero, done && !found, meeting_node == '0)

  // a load finishes in the cycle it is taken
  `FGCM_ASSERT_NEXT(a_load_quick, start && !busy && (opcode == OP_LOAD), !busy && !done)

  // a query keeps the block busy
  `FGCM_ASSERT_NEXT(a_query_busy, start && !busy && (opcode == OP_QUERY), busy && !done)

endmodule

bind functional_graph_closest_meeting_node fgcm_checker u_fgcm_checker (.*);

// ===== dv/functional_graph_closest_meeting_node_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// functional_graph_closest_meeting_node_tb
// self-checking bench for the closest meeting node block
// ----------------------------------------------------------------------------
// Loads edges into the graph and issues meeting queries. A directed table
// comes first, then random phases that each set the node count, build a small
// graph region and query it. Each query result is checked against its known
// table value or a predictor walking its own copy of the edge memory. Queries
// are only issued once every node their walks can read has been loaded.
// ----------------------------------------------------------------------------
module functional_graph_closest_meeting_node_tb;
  import fgcm_pkg::*;

  localparam int                 CLK_HALF      = 5;
  localparam int                 RESET_CYCLES  = 12;
  localparam int                 RANDOM_ITEMS  = 170;
  localparam int                 SETTLE_CYCLES = 8;
  localparam int                 DRAIN_CYCLES  = 60;
  localparam int                 CYCLE_LIMIT   = 4_000_000;
  localparam int                 REGION_MAX    = 24;
  localparam logic [EDGE_W-1:0]  NO_LINK       = 1 << NODE_W;
  localparam logic [EDGE_W-1:0]  UNREACHABLE   = '1;

  typedef enum logic [1:0] {
    ROW_SET_COUNT,
    ROW_LOAD,
    ROW_QUERY,
    ROW_QUERY_KNOWN
  } row_kind_t;

  // n0 is the loaded node or start a, n1 the edge target or start b
  typedef struct packed {
    row_kind_t           kind;
    logic [NODE_W-1:0]   n0;
    logic                link_on;
    logic [NODE_W-1:0]   n1;
    logic [COUNT_W-1:0]  count_raw;
    logic                hit;
    logic [NODE_W-1:0]   node;
  } stim_row_t;

  typedef struct packed {
    logic              hit;
    logic [NODE_W-1:0] node;
  } meeting_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               start = 1'b0;
  logic               busy;
  logic               opcode = OP_LOAD;
  logic [NODE_W-1:0]  node_index = '0;
  logic               has_edge = 1'b0;
  logic [NODE_W-1:0]  edge_target = '0;
  logic [NODE_W-1:0]  start_a = '0;
  logic [NODE_W-1:0]  start_b = '0;
  logic               done;
  logic               found;
  logic [NODE_W-1:0]  meeting_node;

  // predictor state
  logic [EDGE_W-1:0]  link_mem [MAX_NODES];
  bit                 node_loaded [MAX_NODES];
  logic [EDGE_W-1:0]  hops_tbl [2][MAX_NODES];
  int unsigned        nodes_in_use = MAX_NODES;

  meeting_t           pending_meetings [$];
  stim_row_t          directed_rows [$];
  int                 mismatches = 0;
  int                 accepted_items = 0;
  int                 burst_left = 0;
  int unsigned        cycle_count = 0;

  functional_graph_closest_meeting_node i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .node_index   (node_index),
    .has_edge     (has_edge),
    .edge_target  (edge_target),
    .start_a      (start_a),
    .start_b      (start_b),
    .done         (done),
    .found        (found),
    .meeting_node (meeting_node)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    meeting_t want;
    if (!rst && done) begin
      if (pending_meetings.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result found %0b node %0d", $time, found, meeting_node);
      end else begin
        want = pending_meetings.pop_front();
        if (found !== want.hit) begin
          mismatches++;
          $display("%0t: found mismatch, expected %0b, actual %0b", $time, want.hit, found);
        end
        if (meeting_node !== want.node) begin
          mismatches++;
          $display("%0t: meeting_node mismatch, expected %0d, actual %0d",
                   $time, want.node, meeting_node);
        end
      end
    end
  end

  function automatic int unsigned clamp_count(input logic [COUNT_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_NODES) return MAX_NODES;
    return raw;
  endfunction

  // hop distances from one start, stopping at a dead end or a repeat
  function automatic void trace_hops(input logic [NODE_W-1:0] origin, input int side);
    int unsigned       cur;
    logic [EDGE_W-1:0] hops;
    logic [EDGE_W-1:0] link;
    for (int i = 0; i < MAX_NODES; i++) hops_tbl[side][i] = UNREACHABLE;
    cur  = origin;
    hops = '0;
    while (cur < nodes_in_use && hops_tbl[side][cur] == UNREACHABLE) begin
      hops_tbl[side][cur] = hops;
      hops = hops + 1'b1;
      link = link_mem[cur];
      if (link[EDGE_W-1]) break;
      cur = link[NODE_W-1:0];
    end
  endfunction

  // smallest larger-of-two distance, lowest node on ties
  function automatic meeting_t predict_meeting(input logic [NODE_W-1:0] sa,
                                               input logic [NODE_W-1:0] sb);
    meeting_t    res;
    int unsigned worst;
    int unsigned best_worst;
    trace_hops(sa, 0);
    trace_hops(sb, 1);
    res        = '0;
    best_worst = 0;
    for (int i = 0; i < nodes_in_use; i++) begin
      if (hops_tbl[0][i] != UNREACHABLE && hops_tbl[1][i] != UNREACHABLE) begin
        worst = (hops_tbl[0][i] > hops_tbl[1][i]) ? hops_tbl[0][i] : hops_tbl[1][i];
        if (!res.hit || worst < best_worst) begin
          res.hit    = 1'b1;
          res.node   = i[NODE_W-1:0];
          best_worst = worst;
        end
      end
    end
    return res;
  endfunction

  // first node a walk would read before it was ever loaded, or -1
  function automatic int first_unloaded(input logic [NODE_W-1:0] origin);
    bit                seen [MAX_NODES];
    int unsigned       cur;
    logic [EDGE_W-1:0] link;
    cur = origin;
    while (cur < nodes_in_use && !seen[cur]) begin
      if (!node_loaded[cur]) return cur;
      seen[cur] = 1'b1;
      link = link_mem[cur];
      if (link[EDGE_W-1]) break;
      cur = link[NODE_W-1:0];
    end
    return -1;
  endfunction

  function automatic stim_row_t row_count(input logic [COUNT_W-1:0] raw);
    stim_row_t r;
    r           = '0;
    r.kind      = ROW_SET_COUNT;
    r.count_raw = raw;
    return r;
  endfunction

  function automatic stim_row_t row_load(input logic [NODE_W-1:0] idx, input logic on,
                                         input logic [NODE_W-1:0] tgt);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_LOAD;
    r.n0      = idx;
    r.link_on = on;
    r.n1      = tgt;
    return r;
  endfunction

  function automatic stim_row_t row_query(input logic [NODE_W-1:0] sa,
                                          input logic [NODE_W-1:0] sb);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_QUERY;
    r.n0   = sa;
    r.n1   = sb;
    return r;
  endfunction

  function automatic stim_row_t row_known(input logic [NODE_W-1:0] sa,
                                          input logic [NODE_W-1:0] sb,
                                          input logic hit, input logic [NODE_W-1:0] node);
    stim_row_t r;
    r      = row_query(sa, sb);
    r.kind = ROW_QUERY_KNOWN;
    r.hit  = hit;
    r.node = node;
    return r;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input stim_row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  // raise start and wait for the request to be taken
  task automatic hand_over();
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // sender bursts with random gaps between them
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(13, 60)) @(posedge clk);
      else repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic send_load(input logic [NODE_W-1:0] idx, input logic on,
                           input logic [NODE_W-1:0] tgt);
    opcode      <= OP_LOAD;
    node_index  <= idx;
    has_edge    <= on;
    edge_target <= tgt;
    start_a     <= $urandom;
    start_b     <= $urandom;
    hand_over();
    if (idx < nodes_in_use) begin
      link_mem[idx]    = on ? {1'b0, tgt} : NO_LINK;
      node_loaded[idx] = 1'b1;
    end
    accepted_items++;
    pace();
  endtask

  task automatic send_query(input logic [NODE_W-1:0] sa, input logic [NODE_W-1:0] sb,
                            input logic known, input meeting_t known_res);
    meeting_t want_res;
    opcode      <= OP_QUERY;
    start_a     <= sa;
    start_b     <= sb;
    node_index  <= $urandom;
    has_edge    <= $urandom;
    edge_target <= $urandom;
    hand_over();
    want_res = known ? known_res : predict_meeting(sa, sb);
    pending_meetings = {pending_meetings, want_res};
    accepted_items++;
    pace();
  endtask

  // node count is only written with no query in flight
  task automatic write_node_count(input logic [COUNT_W-1:0] raw);
    start <= 1'b0;
    while (pending_meetings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= raw;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= $urandom;
    nodes_in_use = clamp_count(raw);
    repeat (2) @(posedge clk);
  endtask

  // one random request, mostly inside the current graph region
  task automatic random_request(input int unsigned base, input int unsigned width);
    logic [NODE_W-1:0] idx;
    logic [NODE_W-1:0] tgt;
    logic [NODE_W-1:0] sa;
    logic [NODE_W-1:0] sb;
    int                gap;
    if ($urandom_range(0, 9) < 4) begin
      idx = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, width - 1);
      tgt = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, width - 1);
      send_load(idx, $urandom_range(0, 6) != 0, tgt);
    end else begin
      sa = ($urandom_range(0, 7) == 0) ? $urandom : base + $urandom_range(0, width - 1);
      sb = ($urandom_range(0, 7) == 0) ? $urandom : base + $urandom_range(0, width - 1);
      // fill in any node the walks would read before loading it
      forever begin
        gap = first_unloaded(sa);
        if (gap < 0) gap = first_unloaded(sb);
        if (gap < 0) break;
        tgt = base + $urandom_range(0, width - 1);
        send_load(gap[NODE_W-1:0], $urandom_range(0, 4) != 0, tgt);
      end
      send_query(sa, sb, 1'b0, '0);
    end
  endtask

  initial begin
    int                 random_goal;
    int                 phase;
    int unsigned        width;
    int unsigned        base;
    int                 reqs;
    logic [COUNT_W-1:0] raw;

    // directed table, starting from the reset node count of 1024
    add_row(row_load(0, 1'b0, 0));
    add_row(row_known(0, 0, 1'b1, 0));
    add_row(row_load(1023, 1'b1, 0));
    add_row(row_query(1023, 0));
    add_row(row_load(1, 1'b1, 1023));
    add_row(row_query(1, 1023));
    add_row(row_load(2, 1'b0, 1023));
    add_row(row_known(2, 0, 1'b0, 0));
    add_row(row_load(3, 1'b1, 3));
    add_row(row_known(3, 3, 1'b1, 3));
    add_row(row_load(4, 1'b1, 5));
    add_row(row_load(5, 1'b1, 4));
    add_row(row_query(4, 5));
    add_row(row_query(5, 1023));
    // small graph: loads past the count ignored, far targets end the walk
    add_row(row_count(8));
    add_row(row_load(9, 1'b1, 0));
    add_row(row_known(9, 0, 1'b0, 0));
    add_row(row_load(6, 1'b1, 1000));
    add_row(row_known(6, 6, 1'b1, 6));
    add_row(row_known(1023, 1023, 1'b0, 0));
    // count of zero saturates to one, all ones saturates to 1024
    add_row(row_count(0));
    add_row(row_known(0, 0, 1'b1, 0));
    add_row(row_count('1));
    add_row(row_query(1, 4));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_SET_COUNT: begin
          write_node_count(directed_rows[r].count_raw);
        end
        ROW_LOAD: begin
          send_load(directed_rows[r].n0, directed_rows[r].link_on, directed_rows[r].n1);
        end
        ROW_QUERY: begin
          send_query(directed_rows[r].n0, directed_rows[r].n1, 1'b0, '0);
        end
        default: begin
          send_query(directed_rows[r].n0, directed_rows[r].n1, 1'b1,
                     {directed_rows[r].hit, directed_rows[r].node});
        end
      endcase
    end

    // random phases, each with its own node count and graph region
    random_goal = accepted_items + RANDOM_ITEMS;
    phase = 0;
    while (accepted_items < random_goal) begin
      if (phase == 0) begin
        raw = MAX_NODES;
      end else if (phase == 1) begin
        raw = '0;
      end else begin
        case ($urandom_range(0, 5))
          0:       raw = '0;
          1:       raw = $urandom_range(MAX_NODES + 1, (1 << COUNT_W) - 1);
          2:       raw = MAX_NODES;
          3:       raw = $urandom_range(1, 4);
          4:       raw = $urandom_range(5, 32);
          default: raw = $urandom_range(33, MAX_NODES - 1);
        endcase
      end
      write_node_count(raw);
      width = (nodes_in_use < REGION_MAX) ? nodes_in_use : REGION_MAX;
      base  = $urandom_range(0, nodes_in_use - width);
      reqs  = $urandom_range(18, 30);
      while (reqs > 0 && accepted_items < random_goal) begin
        random_request(base, width);
        reqs--;
      end
      phase++;
    end

    // wait out the last results
    start <= 1'b0;
    while (pending_meetings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
